[rtl/core/lras_pkg.sv]
// Shared types and constants for the line rasterizer.
// Holds the port field widths and the command and status words between
// the controller and the datapath. No dependencies.
`default_nettype none

package lras_pkg;

   // Widths of the fields as they appear on the stream words.
   localparam int FIELD_BITS = 6;
   localparam int COLOR_BITS = 32;

   // Request word: x_begin, y_begin, x_finish, y_finish, color.
   localparam int REQ_DATA_BITS = 56;
   // Response word: pixel_x, pixel_y, pixel_color, padded to whole bytes.
   localparam int RSP_DATA_BITS = 48;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the endpoints and color of an accepted word
      logic setup;     // choose the axes and load the stepping state
      logic step;      // current pixel was taken, advance to the next one
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last;      // current pixel is the final one of the segment
   } status_type;

endpackage

`default_nettype wire

[rtl/core/lras_dp.sv]
// Datapath of the line rasterizer: endpoint capture, axis setup and the
// integer error-term stepper. Depends on lras_pkg.
`default_nettype none

module lras_dp #(
   parameter int COORD_BITS = 6
) (
   input  wire                                  clock,
   input  wire  lras_pkg::cmd_type              cmd,
   output lras_pkg::status_type                 status,
   input  wire  [lras_pkg::FIELD_BITS-1:0]      x_begin,
   input  wire  [lras_pkg::FIELD_BITS-1:0]      y_begin,
   input  wire  [lras_pkg::FIELD_BITS-1:0]      x_finish,
   input  wire  [lras_pkg::FIELD_BITS-1:0]      y_finish,
   input  wire  [lras_pkg::COLOR_BITS-1:0]      color,
   output logic [lras_pkg::FIELD_BITS-1:0]      pixel_x,
   output logic [lras_pkg::FIELD_BITS-1:0]      pixel_y,
   output logic [lras_pkg::COLOR_BITS-1:0]      pixel_color
);

   localparam int FB = lras_pkg::FIELD_BITS;
   localparam int CB = COORD_BITS;
   localparam int EB = COORD_BITS + 2;   // error term holds values below 4*span
   localparam int LB = COORD_BITS + 1;   // pixel count reaches 2**COORD_BITS

   // Captured segment.
   logic [CB-1:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic [lras_pkg::COLOR_BITS-1:0] color_ff;

   // Stepping state.
   logic [CB-1:0] major_ff, major_in;
   logic [CB-1:0] minor_ff, minor_in;
   logic [EB-1:0] err_ff, err_in;
   logic [CB-1:0] span_ff, span_in;
   logic [CB-1:0] mspan_ff, mspan_in;
   logic [LB-1:0] left_ff, left_in;
   logic          xmaj_ff, xmaj_in;
   logic          down_ff, down_in;

   // Setup logic.
   logic [CB-1:0] dx, dy;
   logic [CB-1:0] a0, a1, b0, b1;
   logic [CB-1:0] maj0, maj1, min0, min1;
   logic          x_major;

   // Stepper logic.
   logic [EB-1:0] two_span, two_mspan, err_sum;

   always_comb begin
      dx = (x0_ff > x1_ff) ? (x0_ff - x1_ff) : (x1_ff - x0_ff);
      dy = (y0_ff > y1_ff) ? (y0_ff - y1_ff) : (y1_ff - y0_ff);
      x_major = (dx != '0) && (dx >= dy);
      if (x_major) begin
         a0 = x0_ff; a1 = x1_ff; b0 = y0_ff; b1 = y1_ff;
      end else begin
         a0 = y0_ff; a1 = y1_ff; b0 = x0_ff; b1 = x1_ff;
      end
      // Walk from the endpoint with the smaller major coordinate.
      if (a0 > a1) begin
         maj0 = a1; maj1 = a0; min0 = b1; min1 = b0;
      end else begin
         maj0 = a0; maj1 = a1; min0 = b0; min1 = b1;
      end
   end

   always_comb begin
      two_span  = {1'b0, span_ff, 1'b0};
      two_mspan = {1'b0, mspan_ff, 1'b0};
      err_sum   = err_ff + two_mspan;

      major_in = major_ff;
      minor_in = minor_ff;
      err_in   = err_ff;
      span_in  = span_ff;
      mspan_in = mspan_ff;
      left_in  = left_ff;
      xmaj_in  = xmaj_ff;
      down_in  = down_ff;

      if (cmd.setup) begin
         xmaj_in  = x_major;
         major_in = maj0;
         minor_in = min0;
         span_in  = maj1 - maj0;
         mspan_in = (min0 > min1) ? (min0 - min1) : (min1 - min0);
         down_in  = (min1 < min0);
         // The error term starts at span, which stands for one half.
         err_in   = EB'(maj1 - maj0);
         left_in  = LB'(maj1 - maj0) + LB'(1);
      end else if (cmd.step) begin
         left_in  = left_ff - LB'(1);
         major_in = major_ff + CB'(1);
         if (!down_ff) begin
            if (err_sum >= two_span) begin
               err_in   = err_sum - two_span;
               minor_in = minor_ff + CB'(1);
            end else begin
               err_in   = err_sum;
            end
         end else begin
            if (err_ff < two_mspan) begin
               err_in   = err_ff + two_span - two_mspan;
               minor_in = minor_ff - CB'(1);
            end else begin
               err_in   = err_ff - two_mspan;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x0_ff    <= x_begin[CB-1:0];
         y0_ff    <= y_begin[CB-1:0];
         x1_ff    <= x_finish[CB-1:0];
         y1_ff    <= y_finish[CB-1:0];
         color_ff <= color;
      end
      major_ff <= major_in;
      minor_ff <= minor_in;
      err_ff   <= err_in;
      span_ff  <= span_in;
      mspan_ff <= mspan_in;
      left_ff  <= left_in;
      xmaj_ff  <= xmaj_in;
      down_ff  <= down_in;
   end

   always_comb begin
      pixel_x     = FB'(xmaj_ff ? major_ff : minor_ff);
      pixel_y     = FB'(xmaj_ff ? minor_ff : major_ff);
      pixel_color = color_ff;
      status.last = (left_ff == LB'(1));
   end

endmodule

`default_nettype wire

[rtl/core/lras_ctrl.sv]
// Controller of the line rasterizer: sequences capture, setup and pixel
// emission and owns the stream handshakes. Depends on lras_pkg.
`default_nettype none

module lras_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   input  wire  lras_pkg::status_type status,
   output lras_pkg::cmd_type     cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      valid_ff;

   always_comb begin
      req_tready  = ready_ff;
      rsp_tvalid  = valid_ff;
      cmd.capture = req_tvalid && ready_ff;
      cmd.setup   = (state_ff == ST_SETUP);
      cmd.step    = valid_ff && rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && ready_ff) begin
                  state_ff <= ST_SETUP;
                  ready_ff <= 1'b0;
               end else begin
                  ready_ff <= 1'b1;
               end
            end
            ST_SETUP: begin
               state_ff <= ST_RUN;
               valid_ff <= 1'b1;
            end
            ST_RUN: begin
               if (rsp_tready && status.last) begin
                  state_ff <= ST_IDLE;
                  valid_ff <= 1'b0;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b0;
               valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[rtl/core/line_rasterizer.sv]
// Top level of the line rasterizer: stream ports, controller and datapath.
// Depends on lras_pkg, lras_ctrl and lras_dp.
//
// Usage: each request word carries one segment (two endpoints and a color).
// The block answers with one response word per pixel of the segment, in
// ascending order along the axis with the larger span (x on a tie), and raises rsp_tlast
// on the final pixel. The minor coordinate is rounded half up with an exact
// integer error term, so no fractional arithmetic is involved.
//
// Timing: a request word is taken, the next cycle sets up the axes, and then
// one pixel leaves per cycle while rsp_tready is high. One segment is worked
// on at a time; req_tready stays low until the last pixel has been taken.
//
// Reset is synchronous and active high. It returns the controller to idle
// and drops both valid and ready; ready rises in the cycle after reset ends.
// When the receiver stalls, the current pixel is held steady on the
// response port and the stepper waits.
`default_nettype none

module line_rasterizer #(
   parameter int COORD_BITS = 6
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // Fields from bit 0 up: x_begin[5:0], y_begin[11:6], x_finish[17:12],
   // y_finish[23:18], color[55:24].
   input  wire  [lras_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0 up: pixel_x[5:0], pixel_y[11:6], pixel_color[43:12],
   // zero padding[47:44].
   output logic [lras_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready
);

   localparam int FB = lras_pkg::FIELD_BITS;
   localparam int KB = lras_pkg::COLOR_BITS;
   localparam int PAD_BITS = lras_pkg::RSP_DATA_BITS - 2 * FB - KB;

   lras_pkg::cmd_type    cmd;
   lras_pkg::status_type status;

   logic [FB-1:0] pixel_x, pixel_y;
   logic [KB-1:0] pixel_color;

   // The controller owns both handshakes and tells the datapath when to
   // capture a segment, when to set it up and when a pixel has been taken.
   lras_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the segment and the current pixel in registers, so
   // the response word is stable for as long as the receiver stalls.
   lras_dp #(
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock       (clock),
      .cmd         (cmd),
      .status      (status),
      .x_begin     (req_tdata[FB-1:0]),
      .y_begin     (req_tdata[2*FB-1:FB]),
      .x_finish    (req_tdata[3*FB-1:2*FB]),
      .y_finish    (req_tdata[4*FB-1:3*FB]),
      .color       (req_tdata[4*FB+KB-1:4*FB]),
      .pixel_x     (pixel_x),
      .pixel_y     (pixel_y),
      .pixel_color (pixel_color)
   );

   assign rsp_tdata = {{PAD_BITS{1'b0}}, pixel_color, pixel_y, pixel_x};
   assign rsp_tlast = status.last;

endmodule

`default_nettype wire
